/* rtl/evag_pkg.sv */
// Shared types and constants for the energy voice activity gate.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package evag_pkg;

   localparam int MAX_FRAME_LEN = 1024;
   localparam int POS_W         = $clog2(MAX_FRAME_LEN);
   localparam int LEN_W         = 11;
   localparam int ENERGY_W      = 41;
   localparam int SIL_W         = 11;
   localparam int UTT_W         = 12;
   localparam int SAMPLE_W      = 16;
   localparam int SQ_W          = 2 * SAMPLE_W;

   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 5;

   localparam logic [LEN_W-1:0]    FRAME_LENGTH_RST = LEN_W'(320);
   localparam logic [ENERGY_W-1:0] THRESHOLD_RST    = ENERGY_W'(34359738);
   localparam logic [SIL_W-1:0]    SILENCE_RST      = SIL_W'(40);
   localparam logic [UTT_W-1:0]    MAX_FRAMES_RST   = UTT_W'(1500);

   localparam logic [LEN_W-1:0]    LEN_MAX   = LEN_W'(MAX_FRAME_LEN);
   localparam logic [SIL_W-1:0]    QUIET_SAT = '1;
   localparam logic [UTT_W-1:0]    UTT_SAT   = '1;
   localparam logic [ENERGY_W-1:0] ENERGY_SAT = '1;

   typedef enum logic [1:0] {
      REG_FRAME_LENGTH = 2'd0,
      REG_THRESHOLD    = 2'd1,
      REG_SILENCE      = 2'd2,
      REG_MAX_FRAMES   = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      CAUSE_NONE    = 2'd0,
      CAUSE_SILENCE = 2'd1,
      CAUSE_CAP     = 2'd2,
      CAUSE_STOP    = 2'd3
   } cause_type;

   typedef struct packed {
      logic [LEN_W-1:0]    frame_length;
      logic [ENERGY_W-1:0] energy_threshold;
      logic [SIL_W-1:0]    silence_frames;
      logic [UTT_W-1:0]    max_frames;
   } cfg_type;

endpackage

/* rtl/evag_if.sv */
// Request and response channel interfaces (valid/ready plus payload).
// Depends on evag_pkg.
`timescale 1ns / 1ps

interface evag_req_if import evag_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       listen;
   logic                       stop_request;

   modport source (output valid, output sample, output listen, output stop_request,
                   input ready);
   modport sink   (input valid, input sample, input listen, input stop_request,
                   output ready);
endinterface

interface evag_rsp_if import evag_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                frame_kept;
   logic                frame_voiced;
   logic [ENERGY_W-1:0] frame_energy;
   logic                utterance_done;
   logic [1:0]          end_cause;

   modport source (output valid, output frame_kept, output frame_voiced,
                   output frame_energy, output utterance_done, output end_cause,
                   input ready);
   modport sink   (input valid, input frame_kept, input frame_voiced,
                   input frame_energy, input utterance_done, input end_cause,
                   output ready);
endinterface

/* rtl/energy_voice_activity_gate.sv */
// Energy voice activity gate: per-sample square-accumulate and per-frame decision.
// Registers: the request is held in the input register and its result in the result
//   register; a held request waits there while the result register is full and not taken.
// Throughput: one request per cycle while the response side takes results;
//   set by the single square-accumulate and frame decision between the registers.
// Reset: synchronous active-high; idle, counters and accumulator cleared,
//   config registers return to their defaults. Depends on evag_pkg, evag_if, evag_csr.
`timescale 1ns / 1ps

module energy_voice_activity_gate import evag_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   evag_req_if.sink              req_bus,
   evag_rsp_if.source            rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   evag_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ---------------- input register ----------------
   logic                       in_valid_ff, in_valid_in;
   logic signed [SAMPLE_W-1:0] in_sample_ff;
   logic                       in_listen_ff;
   logic                       in_stop_ff;
   logic                       advance;
   logic                       out_valid_ff, out_valid_in;

   // Process the held request whenever the result slot is free or draining.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.ready) in_valid_in = req_bus.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_sample_ff <= req_bus.sample;
         in_listen_ff <= req_bus.listen;
         in_stop_ff   <= req_bus.stop_request;
      end
   end

   // ---------------- gate state ----------------
   logic                speech_ff, speech_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [ENERGY_W-1:0] acc_ff, acc_in;
   logic [SIL_W-1:0]    quiet_ff, quiet_in;
   logic [UTT_W-1:0]    utt_ff, utt_in;

   // ---------------- frame datapath ----------------
   logic signed [SQ_W-1:0] sq_s;
   logic [ENERGY_W:0]      sum;
   logic [ENERGY_W-1:0]    energy;
   logic [LEN_W-1:0]       len;
   logic                   frame_end;
   logic                   voiced;
   logic [SIL_W-1:0]       quiet_next;
   logic [UTT_W-1:0]       utt_next;

   // square is never negative, so its top bit is always zero
   assign sq_s   = in_sample_ff * in_sample_ff;
   assign sum    = {1'b0, acc_ff} + (ENERGY_W + 1)'($unsigned(sq_s));
   assign energy = sum[ENERGY_W] ? ENERGY_SAT : sum[ENERGY_W-1:0];

   // zero length acts as one, oversize clamps to the max frame
   always_comb begin
      if (cfg.frame_length == '0)      len = LEN_W'(1);
      else if (cfg.frame_length > LEN_MAX) len = LEN_MAX;
      else                             len = cfg.frame_length;
   end

   // also catches a position already past a freshly lowered length
   assign frame_end = !((LEN_W'(pos_ff) + LEN_W'(1)) < len);
   assign voiced    = energy >= cfg.energy_threshold;

   assign quiet_next = voiced ? '0 : ((quiet_ff == QUIET_SAT) ? quiet_ff : quiet_ff + 1'b1);
   assign utt_next   = (utt_ff == UTT_SAT) ? utt_ff : utt_ff + 1'b1;

   // result fields prepared for the output register
   logic      res_valid;
   logic      res_kept;
   logic      res_voiced;
   logic      res_done;
   cause_type res_cause;
   logic [ENERGY_W-1:0] res_energy;

   always_comb begin
      speech_in  = speech_ff;
      pos_in     = pos_ff;
      acc_in     = acc_ff;
      quiet_in   = quiet_ff;
      utt_in     = utt_ff;
      res_valid  = 1'b0;
      res_kept   = 1'b0;
      res_voiced = 1'b0;
      res_done   = 1'b0;
      res_cause  = CAUSE_NONE;
      res_energy = '0;

      if (advance) begin
         if (in_stop_ff) begin
            // stop: drop the partial frame, report and go idle
            speech_in = 1'b0;
            pos_in    = '0;
            acc_in    = '0;
            quiet_in  = '0;
            utt_in    = '0;
            res_valid = 1'b1;
            res_done  = 1'b1;
            res_cause = CAUSE_STOP;
         end else if (!frame_end) begin
            acc_in = energy;
            pos_in = pos_ff + 1'b1;
         end else begin
            acc_in     = '0;
            pos_in     = '0;
            res_valid  = 1'b1;
            res_voiced = voiced;
            res_energy = energy;
            if (!speech_ff) begin
               if (in_listen_ff && voiced) begin
                  speech_in = 1'b1;
                  quiet_in  = '0;
                  utt_in    = UTT_W'(1);
                  res_kept  = 1'b1;
               end
            end else begin
               res_kept = 1'b1;
               quiet_in = quiet_next;
               utt_in   = utt_next;
               // silence wins over the cap
               if (!voiced && (quiet_next >= cfg.silence_frames)) begin
                  res_done  = 1'b1;
                  res_cause = CAUSE_SILENCE;
               end else if (utt_next >= cfg.max_frames) begin
                  res_done  = 1'b1;
                  res_cause = CAUSE_CAP;
               end
               if (res_done) begin
                  speech_in = 1'b0;
                  quiet_in  = '0;
                  utt_in    = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speech_ff <= 1'b0;
         pos_ff    <= '0;
         acc_ff    <= '0;
         quiet_ff  <= '0;
         utt_ff    <= '0;
      end else begin
         speech_ff <= speech_in;
         pos_ff    <= pos_in;
         acc_ff    <= acc_in;
         quiet_ff  <= quiet_in;
         utt_ff    <= utt_in;
      end
   end

   // ---------------- result register ----------------
   logic                out_kept_ff;
   logic                out_voiced_ff;
   logic [ENERGY_W-1:0] out_energy_ff;
   logic                out_done_ff;
   cause_type           out_cause_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_bus.ready) out_valid_in = 1'b0;
      if (res_valid)     out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         out_kept_ff   <= res_kept;
         out_voiced_ff <= res_voiced;
         out_energy_ff <= res_energy;
         out_done_ff   <= res_done;
         out_cause_ff  <= res_cause;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.frame_kept     = out_kept_ff;
   assign rsp_bus.frame_voiced   = out_voiced_ff;
   assign rsp_bus.frame_energy   = out_energy_ff;
   assign rsp_bus.utterance_done = out_done_ff;
   assign rsp_bus.end_cause      = out_cause_ff;

   // ---------------- checks ----------------
   a_done_has_cause: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_done_ff == (out_cause_ff != CAUSE_NONE)))
      else $error("utterance_done and end_cause disagree");

   a_stop_empty: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_cause_ff == CAUSE_STOP) |->
         (!out_kept_ff && !out_voiced_ff && out_energy_ff == '0))
      else $error("stop response carries frame data");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_done) |=> (!speech_ff && utt_ff == '0 && pos_ff == '0))
      else $error("state not idle after utterance end");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |-> !advance)
      else $error("pending response overwritten");

endmodule

/* rtl/evag_csr.sv */
// APB-style configuration registers for the voice activity gate.
// Depends on evag_pkg.
`timescale 1ns / 1ps

module evag_csr import evag_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign idx        = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_FRAME_LENGTH: cfg_in.frame_length     = csr_pwdata[LEN_W-1:0];
            REG_THRESHOLD:    cfg_in.energy_threshold = csr_pwdata[ENERGY_W-1:0];
            REG_SILENCE:      cfg_in.silence_frames   = csr_pwdata[SIL_W-1:0];
            REG_MAX_FRAMES:   cfg_in.max_frames       = csr_pwdata[UTT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_FRAME_LENGTH: csr_prdata = CSR_DATA_W'(cfg_ff.frame_length);
         REG_THRESHOLD:    csr_prdata = CSR_DATA_W'(cfg_ff.energy_threshold);
         REG_SILENCE:      csr_prdata = CSR_DATA_W'(cfg_ff.silence_frames);
         REG_MAX_FRAMES:   csr_prdata = CSR_DATA_W'(cfg_ff.max_frames);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_length     <= FRAME_LENGTH_RST;
         cfg_ff.energy_threshold <= THRESHOLD_RST;
         cfg_ff.silence_frames   <= SILENCE_RST;
         cfg_ff.max_frames       <= MAX_FRAMES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* tb/sv/tb_energy_voice_activity_gate.sv */
// Self-checking testbench for energy_voice_activity_gate: directed table, then
// random phases under several register settings, checked against a local predictor.
// Depends on evag_pkg, evag_if and the gate RTL.
`timescale 1ns / 1ps

module tb_energy_voice_activity_gate;
   import evag_pkg::*;

   localparam int SETTLE_CYCLES   = 6;     // keep some margin after the last response
   localparam int HOLD_OFF_CYCLES = 300;   // long response stall, fills the pipe
   localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no handshake at all
   localparam int REPORT_CAP      = 100;   // keep the log short on a broken build
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_ITEMS     = 48;
   localparam int OVERSIZE_ITEMS  = 140;   // full-scale run under an oversize length
   localparam int ROW_COUNT       = 21;
   localparam int RESET_ROWS      = 2;     // rows run under the reset register values

   // Square of full scale (-32768) and of the largest positive sample.
   localparam logic [ENERGY_W-1:0] FULL_SQ = ENERGY_W'(1) << 30;
   localparam logic [ENERGY_W-1:0] NEAR_SQ = ENERGY_W'(1073676289);

   // One frame decision, laid out like the response payload.
   typedef struct packed {
      logic                kept;
      logic                voiced;
      logic [ENERGY_W-1:0] energy;
      logic                done;
      cause_type           cause;
   } gate_decision_type;

   // How a directed row is checked.
   typedef enum logic [1:0] {
      CHECK_MODEL,   // expectation comes from the predictor
      CHECK_SILENT,  // no response may come from this request
      CHECK_TYPED    // expectation typed into the row
   } row_check_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       listen;
      logic                       stop;
      row_check_type              check;
      gate_decision_type          want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   evag_req_if req_chan ();
   evag_rsp_if rsp_chan ();

   energy_voice_activity_gate u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_chan),
      .rsp_bus     (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor copy of the registers and of the gate state.
   cfg_type             gate_cfg;
   logic                speaking;
   int unsigned         frame_pos;
   logic [ENERGY_W-1:0] energy_acc;
   logic [SIL_W-1:0]    quiet_run;
   logic [UTT_W-1:0]    utt_frames;

   gate_decision_type expected_decisions[$];
   gate_decision_type oldest_decision;
   int                mismatch_count;
   int                stall_cycles;
   bit                no_gaps;
   bit                hold_off_armed;

   // Directed table. Under the directed settings every sample is a frame
   // (length 1), only full scale is voiced, two quiet frames end an
   // utterance and five frames cap it.
   stim_row_type directed_rows [ROW_COUNT] = '{
      // reset settings: 320-sample frames, so a single sample is mid-frame
      '{16'sh8000, 1'b1, 1'b0, CHECK_SILENT, '0},
      // stop drops the partial frame, answered even while idle
      '{16'sh0000, 1'b0, 1'b1, CHECK_TYPED, '{1'b0, 1'b0, '0, 1'b1, CAUSE_STOP}},
      // loud but not listening: reported, not kept
      '{16'sh8000, 1'b0, 1'b0, CHECK_TYPED, '{1'b0, 1'b1, FULL_SQ, 1'b0, CAUSE_NONE}},
      // listening but just under the threshold
      '{16'sh7fff, 1'b1, 1'b0, CHECK_TYPED, '{1'b0, 1'b0, NEAR_SQ, 1'b0, CAUSE_NONE}},
      // energy exactly at the threshold starts an utterance
      '{16'sh8000, 1'b1, 1'b0, CHECK_TYPED, '{1'b1, 1'b1, FULL_SQ, 1'b0, CAUSE_NONE}},
      '{16'sh7fff, 1'b1, 1'b0, CHECK_TYPED, '{1'b1, 1'b0, NEAR_SQ, 1'b0, CAUSE_NONE}},
      // second quiet frame: trailing silence
      '{16'sh0000, 1'b0, 1'b0, CHECK_TYPED, '{1'b1, 1'b0, '0, 1'b1, CAUSE_SILENCE}},
      '{16'sh8000, 1'b1, 1'b0, CHECK_TYPED, '{1'b1, 1'b1, FULL_SQ, 1'b0, CAUSE_NONE}},
      // listen only matters while idle
      '{16'sh8000, 1'b0, 1'b0, CHECK_TYPED, '{1'b1, 1'b1, FULL_SQ, 1'b0, CAUSE_NONE}},
      '{16'sh8000, 1'b0, 1'b0, CHECK_TYPED, '{1'b1, 1'b1, FULL_SQ, 1'b0, CAUSE_NONE}},
      '{16'sh0001, 1'b0, 1'b0, CHECK_TYPED, '{1'b1, 1'b0, 41'd1, 1'b0, CAUSE_NONE}},
      // fifth frame and second quiet one at once: silence wins over the cap
      '{16'shffff, 1'b1, 1'b0, CHECK_TYPED, '{1'b1, 1'b0, 41'd1, 1'b1, CAUSE_SILENCE}},
      '{16'sh8000, 1'b1, 1'b0, CHECK_TYPED, '{1'b1, 1'b1, FULL_SQ, 1'b0, CAUSE_NONE}},
      '{16'sh8000, 1'b0, 1'b0, CHECK_MODEL, '0},
      '{16'sh8000, 1'b0, 1'b0, CHECK_MODEL, '0},
      '{16'sh8000, 1'b0, 1'b0, CHECK_MODEL, '0},
      // fifth loud frame: length cap
      '{16'sh8000, 1'b0, 1'b0, CHECK_TYPED, '{1'b1, 1'b1, FULL_SQ, 1'b1, CAUSE_CAP}},
      '{16'sh8000, 1'b1, 1'b0, CHECK_TYPED, '{1'b1, 1'b1, FULL_SQ, 1'b0, CAUSE_NONE}},
      // stop in the middle of an utterance, sample ignored
      '{16'sh5555, 1'b1, 1'b1, CHECK_TYPED, '{1'b0, 1'b0, '0, 1'b1, CAUSE_STOP}},
      '{16'sh7fff, 1'b1, 1'b0, CHECK_TYPED, '{1'b0, 1'b0, NEAR_SQ, 1'b0, CAUSE_NONE}},
      '{16'shaaaa, 1'b0, 1'b1, CHECK_TYPED, '{1'b0, 1'b0, '0, 1'b1, CAUSE_STOP}}
   };

   initial clock = 1'b0;
   always #1 clock = ~clock;

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
         $display("MISMATCH %s: got 0x%0h, want 0x%0h", what, got, want);
   endtask

   function automatic bit take_gap();
      return !no_gaps && ($urandom_range(99) < 21);
   endfunction

   function automatic void clear_gate_state();
      speaking   = 1'b0;
      frame_pos  = 0;
      energy_acc = '0;
      quiet_run  = '0;
      utt_frames = '0;
   endfunction

   // Advances the predictor by one request; returns 1 when it yields a decision.
   function automatic bit predict_decision(input logic signed [SAMPLE_W-1:0] smp,
                                           input logic lis, input logic stp,
                                           output gate_decision_type d);
      int                  s_val;
      logic [ENERGY_W:0]   sq_val;
      logic [ENERGY_W:0]   sum;
      int unsigned         eff_len;
      logic [ENERGY_W-1:0] frame_e;
      logic                loud;
      d       = '0;
      d.cause = CAUSE_NONE;
      if (stp) begin
         clear_gate_state();
         d.done  = 1'b1;
         d.cause = CAUSE_STOP;
         return 1'b1;
      end
      s_val      = int'(smp);
      sq_val     = (ENERGY_W + 1)'(s_val * s_val);
      sum        = {1'b0, energy_acc} + sq_val;
      energy_acc = sum[ENERGY_W] ? ENERGY_SAT : sum[ENERGY_W-1:0];
      // zero acts as one, oversize acts as the largest frame
      eff_len = 32'(gate_cfg.frame_length);
      if (eff_len == 0) eff_len = 1;
      if (eff_len > MAX_FRAME_LEN) eff_len = MAX_FRAME_LEN;
      if (frame_pos + 1 < eff_len) begin
         frame_pos++;
         return 1'b0;
      end
      frame_e    = energy_acc;
      energy_acc = '0;
      frame_pos  = 0;
      loud       = (frame_e >= gate_cfg.energy_threshold);
      d.voiced   = loud;
      d.energy   = frame_e;
      if (!speaking) begin
         if (lis && loud) begin
            // opening frame counts as one and skips the cap test
            speaking   = 1'b1;
            quiet_run  = '0;
            utt_frames = UTT_W'(1);
            d.kept     = 1'b1;
         end
      end else begin
         d.kept = 1'b1;
         if (utt_frames != UTT_SAT) utt_frames++;
         if (loud) quiet_run = '0;
         else if (quiet_run != QUIET_SAT) quiet_run++;
         if (!loud && quiet_run >= gate_cfg.silence_frames) begin
            d.done  = 1'b1;
            d.cause = CAUSE_SILENCE;
         end else if (utt_frames >= gate_cfg.max_frames) begin
            d.done  = 1'b1;
            d.cause = CAUSE_CAP;
         end
         if (d.done) clear_gate_state();
      end
      return 1'b1;
   endfunction

   // Offer one request; returns at the edge where it is taken.
   task automatic offer_sample(input logic signed [SAMPLE_W-1:0] smp,
                               input logic lis, input logic stp);
      @(negedge clock);
      while (take_gap()) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.sample       <= smp;
      req_chan.listen       <= lis;
      req_chan.stop_request <= stp;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Stop requesting and let every outstanding decision and in-flight
   // mid-frame sample work through the block.
   task automatic drain_requests();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_decisions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write (setup + access), then read back the same register.
   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << 3;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value)
         flag_mismatch($sformatf("register %s readback", idx.name()), csr_prdata, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_gate(input cfg_type plan);
      drain_requests();
      csr_write(REG_FRAME_LENGTH, CSR_DATA_W'(plan.frame_length));
      csr_write(REG_THRESHOLD,    CSR_DATA_W'(plan.energy_threshold));
      csr_write(REG_SILENCE,      CSR_DATA_W'(plan.silence_frames));
      csr_write(REG_MAX_FRAMES,   CSR_DATA_W'(plan.max_frames));
      gate_cfg = plan;
   endtask

   // Response side: random stalls, plus one long hold-off on request from
   // the main sequence, counted here while the sender keeps offering.
   initial begin
      bit hold_off_done;
      hold_off_done  = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_armed && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            rsp_chan.ready <= !take_gap();
         end
      end
   end

   // Response checker: every taken response against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_decisions.size() == 0) begin
            flag_mismatch("response with nothing outstanding", rsp_chan.frame_energy, '0);
         end else begin
            oldest_decision = expected_decisions.pop_front();
            if (rsp_chan.frame_kept !== oldest_decision.kept)
               flag_mismatch("frame_kept", rsp_chan.frame_kept, oldest_decision.kept);
            if (rsp_chan.frame_voiced !== oldest_decision.voiced)
               flag_mismatch("frame_voiced", rsp_chan.frame_voiced, oldest_decision.voiced);
            if (rsp_chan.frame_energy !== oldest_decision.energy)
               flag_mismatch("frame_energy", rsp_chan.frame_energy, oldest_decision.energy);
            if (rsp_chan.utterance_done !== oldest_decision.done)
               flag_mismatch("utterance_done", rsp_chan.utterance_done,
                             oldest_decision.done);
            if (rsp_chan.end_cause !== oldest_decision.cause)
               flag_mismatch("end_cause", rsp_chan.end_cause, oldest_decision.cause);
         end
      end
   end

   // Watchdog: no handshake on either channel for too long ends the run.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      cfg_type                    plan;
      gate_decision_type          predicted;
      logic signed [SAMPLE_W-1:0] smp;
      logic                       lis;
      logic                       stp;
      int                         n_items;
      int                         mag;
      int unsigned                frame_mode;

      // Every input known from time zero.
      reset                 = 1'b1;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      req_chan.valid        = 1'b0;
      req_chan.sample       = '0;
      req_chan.listen       = 1'b0;
      req_chan.stop_request = 1'b0;
      no_gaps               = 1'b0;
      hold_off_armed        = 1'b0;
      frame_mode            = 0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Predictor starts from the reset register values.
      gate_cfg = '{frame_length: FRAME_LENGTH_RST, energy_threshold: THRESHOLD_RST,
                   silence_frames: SILENCE_RST, max_frames: MAX_FRAMES_RST};
      clear_gate_state();

      // Directed table.
      for (int i = 0; i < ROW_COUNT; i++) begin
         if (i == RESET_ROWS)
            program_gate('{frame_length: LEN_W'(1), energy_threshold: FULL_SQ,
                           silence_frames: SIL_W'(2), max_frames: UTT_W'(5)});
         offer_sample(directed_rows[i].sample, directed_rows[i].listen,
                      directed_rows[i].stop);
         if (predict_decision(directed_rows[i].sample, directed_rows[i].listen,
                              directed_rows[i].stop, predicted)) begin
            if (directed_rows[i].check == CHECK_MODEL)
               expected_decisions.push_back(predicted);
         end
         if (directed_rows[i].check == CHECK_TYPED)
            expected_decisions.push_back(directed_rows[i].want);
      end

      // Random phases, each under its own register setting. Phases end at
      // arbitrary points, so a new, shorter frame length can land mid-frame.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         n_items = PHASE_ITEMS;
         case (ph)
            0: plan = '{frame_length: LEN_W'(4), energy_threshold: ENERGY_W'(4) << 24,
                        silence_frames: SIL_W'(2), max_frames: UTT_W'(8)};
            // zero everywhere: length acts as 1, all frames voiced, cut at next frame
            1: plan = '{frame_length: '0, energy_threshold: '0,
                        silence_frames: '0, max_frames: '0};
            // top threshold: nothing is ever voiced
            2: plan = '{frame_length: LEN_W'(3), energy_threshold: ENERGY_SAT,
                        silence_frames: SIL_W'(1500), max_frames: UTT_SAT};
            // oversize length acts as the largest frame: a full-scale run stays
            // mid-frame, and the next phase's short length closes that frame
            3: begin
               plan = '{frame_length: '1, energy_threshold: ENERGY_W'(1) << 40,
                        silence_frames: '1, max_frames: UTT_SAT};
               n_items = OVERSIZE_ITEMS;
            end
            default: begin
               plan.frame_length = ($urandom_range(9) == 0) ?
                  LEN_W'($urandom_range(40, 9)) : LEN_W'($urandom_range(8, 1));
               plan.energy_threshold = ($urandom_range(4) == 0) ?
                  ENERGY_W'({$urandom, $urandom}) >> $urandom_range(40) :
                  ENERGY_W'(plan.frame_length) << 24;
               plan.silence_frames = SIL_W'($urandom_range(4));
               plan.max_frames     = UTT_W'($urandom_range(12));
            end
         endcase
         program_gate(plan);
         no_gaps = (ph == 0);          // one long stretch with no idling
         if (ph == 4) hold_off_armed = 1'b1;

         for (int k = 0; k < n_items; k++) begin
            if (ph == 3) begin
               smp = 16'sh8000;
               lis = 1'b1;
               stp = 1'b0;
            end else begin
               // Loudness picked per frame so frames are mostly clearly voiced
               // or clearly quiet, with some raw noise.
               if (frame_pos == 0) frame_mode = $urandom_range(99);
               lis = ($urandom_range(99) < 85);
               stp = ($urandom_range(99) < 2);
               if (frame_mode < 50) begin
                  mag = $urandom_range(32767, 6000);
                  smp = $urandom_range(1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
               end else if (frame_mode < 85) begin
                  mag = $urandom_range(3000);
                  smp = $urandom_range(1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
               end else begin
                  smp = SAMPLE_W'($urandom);
               end
            end
            offer_sample(smp, lis, stp);
            if (predict_decision(smp, lis, stp, predicted))
               expected_decisions.push_back(predicted);
         end
      end

      no_gaps = 1'b0;
      drain_requests();
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* energy_voice_activity_gate.f */
rtl/evag_pkg.sv
rtl/evag_if.sv
rtl/evag_csr.sv
rtl/energy_voice_activity_gate.sv
tb/sv/tb_energy_voice_activity_gate.sv
